// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file evad_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define CHK_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define CHK_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `CHK_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define CHK_NXT(lbl, clk, rst_n, ante, cons, msg) \
    `CHK_PROP(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== rtl/evad_pkg.sv =====
package evad_pkg;

    // Default sizes
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int HOLD_DEPTH_DEF    = 80;
    localparam int FRAC_BITS_DEF     = 16;

    // Fixed field widths
    localparam int E_W    = 28;
    localparam int CFG_W  = 28;
    localparam int IDX_W  = 3;
    localparam int HOLD_W = 7;
    localparam int LEN_W  = 8;

    // Start-up values
    localparam int INIT_ENERGY = 50000;
    localparam int INIT_THRESH = 30238;

    localparam logic [15:0] RISE_RST   = 16'd33;
    localparam logic [15:0] FALL_RST   = 16'd14418;
    localparam logic [19:0] RATIO_RST  = 20'd99083;
    localparam logic [27:0] MINENV_RST = 28'd1000;
    localparam logic [6:0]  LONG_RST   = 7'd40;
    localparam logic [6:0]  SHORT_RST  = 7'd10;

    typedef enum logic [IDX_W-1:0] {
        CFG_RISE        = 3'd0,
        CFG_FALL        = 3'd1,
        CFG_CHANGE      = 3'd2,
        CFG_SPEECH      = 3'd3,
        CFG_MIN_ENV     = 3'd4,
        CFG_HOLD_LONG   = 3'd5,
        CFG_HOLD_SHORT  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic wr;
        logic clr;
    } t_hist_ctl;

endpackage

// ===== rtl/evad_mul.sv =====
module evad_mul #(
    parameter int A_W = 46,
    parameter int B_W = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int H_W = (A_W + 1) / 2;
    localparam int P_W = A_W + B_W;

    logic               r_busy;
    logic               r_hi;
    logic               r_done;
    logic [2*H_W-1:0]   r_a;
    logic [B_W-1:0]     r_b;
    logic [P_W-1:0]     r_acc;
    logic [H_W-1:0]     chunk;
    logic [H_W+B_W-1:0] part;

    // One half of the multiplicand per cycle through a single multiplier
    assign chunk = r_hi ? r_a[2*H_W-1:H_W] : r_a[H_W-1:0];
    assign part  = (H_W+B_W)'(chunk) * (H_W+B_W)'(r_b);

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_hi   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_hi   <= 1'b0;
            end else if (r_busy) begin
                if (!r_hi) begin
                    r_hi <= 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and partial-product accumulation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= (2*H_W)'(i_a);
            r_b <= i_b;
        end else if (r_busy) begin
            if (!r_hi) begin
                r_acc <= P_W'(part);
            end else begin
                r_acc <= r_acc + (P_W'(part) << H_W);
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/evad_hist.sv =====
module evad_hist #(
    parameter int DEPTH = evad_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  evad_pkg::t_hist_ctl    i_ctl,
    input  logic [evad_pkg::E_W-1:0] i_data,
    output logic [evad_pkg::E_W-1:0] o_old
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [evad_pkg::E_W-1:0] mem [DEPTH];
    logic [evad_pkg::E_W-1:0] r_rd;
    logic [DEPTH-1:0]         r_vld;
    logic                     r_old_vld;
    logic                     r_dflt;
    logic [PTR_W-1:0]         r_ptr;

    // Ring pointer, valid bits and fill value for entries not yet written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_old_vld <= 1'b0;
            r_dflt    <= 1'b1;
            r_ptr     <= '0;
        end else begin
            if (i_ctl.wr) begin
                r_old_vld    <= r_vld[r_ptr];
                r_vld[r_ptr] <= 1'b1;
                r_ptr        <= (r_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);
            end
            if (i_ctl.clr) begin
                r_vld  <= '0;
                r_dflt <= 1'b0;
            end
        end
    end

    // Read the oldest entry and overwrite it with the newest
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_rd       <= mem[r_ptr];
            mem[r_ptr] <= i_data;
        end
    end

    assign o_old = r_old_vld ? r_rd :
                   (r_dflt ? evad_pkg::E_W'(evad_pkg::INIT_ENERGY) : '0);

endmodule

// ===== rtl/energy_voice_activity_detector.sv =====
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_stall   i_sample, i_block_end
// output    o_out_valid / i_out_stall o_speech_now, o_speech_long, o_speech_short,
//                                     o_frame_energy
// config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A sample without frame end does not stall the input. A frame end stalls the input for
// eight multiplies through one shared two-pass multiplier, plus
// the history read and sum, envelope clamp, noise, decision and hangover steps.
// Reset is synchronous; the history reads as 50000 per entry until overwritten or cleared (then 0).
// Input stall is high while a frame end is processed or its result cannot be
// loaded because the output register is still held by a stall.
module energy_voice_activity_detector #(
    parameter int HISTORY_DEPTH = evad_pkg::HISTORY_DEPTH_DEF,
    parameter int HOLD_DEPTH    = evad_pkg::HOLD_DEPTH_DEF,
    parameter int FRAC_BITS     = evad_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [15:0]         i_sample,
    input  logic                       i_block_end,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_speech_now,
    output logic                       o_speech_long,
    output logic                       o_speech_short,
    output logic [evad_pkg::E_W-1:0]   o_frame_energy,
    input  logic                       i_cfg_we,
    input  logic [evad_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [evad_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int EW  = evad_pkg::E_W + F;
    localparam int TW  = 30 + F;
    localparam int BW  = (F + 1 > 20) ? F + 1 : 20;
    localparam int PW  = TW + BW;
    localparam int XW  = PW + 4;
    localparam int SW  = 25 + $clog2(HISTORY_DEPTH) + 1;
    localparam int NW  = SW - 4;
    localparam int LW  = evad_pkg::LEN_W;

    localparam logic [XW-1:0] QONE    = XW'(1) << F;
    localparam logic [XW-1:0] HALF    = XW'(1) << (F - 1);
    localparam logic [XW-1:0] ENV_MAX = (XW'(1) << EW) - XW'(1);
    localparam logic [XW-1:0] THR_MAX = (XW'(1) << TW) - XW'(1);
    localparam logic [XW-1:0] Q_NINE  = XW'(((9 << FRAC_BITS) + 5) / 10);
    localparam logic [XW-1:0] Q_SLOW  = XW'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic [XW-1:0] Q_FAST  = XW'(1 << (FRAC_BITS - 3));
    localparam logic [SW-1:0] SUM_INIT =
        SW'(HISTORY_DEPTH * ((evad_pkg::INIT_ENERGY + 2) / 4));

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_SUM   = 10'b0000000100,
        S_GO    = 10'b0000001000,
        S_WAIT  = 10'b0000010000,
        S_POST  = 10'b0000100000,
        S_ENV   = 10'b0001000000,
        S_NOISE = 10'b0010000000,
        S_DEC   = 10'b0100000000,
        S_HOLD  = 10'b1000000000
    } t_state;

    typedef enum logic [2:0] {
        OP_ENV_KEEP = 3'd0,
        OP_ENV_RATE = 3'd1,
        OP_CT_TGT   = 3'd2,
        OP_CT_OLD   = 3'd3,
        OP_CT_NEW   = 3'd4,
        OP_ST_TGT   = 3'd5,
        OP_ST_OLD   = 3'd6,
        OP_ST_NEW   = 3'd7
    } t_op;

    function automatic logic [XW-1:0] f_min(logic [XW-1:0] a, logic [XW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Configuration
    logic [15:0]   r_rise, r_fall;
    logic [19:0]   r_cratio, r_sratio;
    logic [27:0]   r_min_env;
    logic [6:0]    r_hold_long, r_hold_short;

    // Control and detector state
    t_state                  r_state;
    t_op                     r_op;
    logic [30:0]             r_acc;
    logic [evad_pkg::E_W-1:0] r_e;
    logic [SW-1:0]           r_sum;
    logic [NW-1:0]           r_noise;
    logic [EW-1:0]           r_env;
    logic [TW-1:0]           r_cthr, r_sthr;
    logic [TW-1:0]           r_t1, r_tgt;
    logic [BW-1:0]           r_tau;
    logic [evad_pkg::E_W-1:0] r_floor;
    logic                    r_rise_sel;
    logic                    r_in_speech;
    logic                    r_raw_prev;
    logic [HOLD_DEPTH-1:0]   r_conf;
    logic                    r_out_vld;
    logic                    r_now, r_long, r_short;
    logic [evad_pkg::E_W-1:0] r_energy;

    // Datapath helpers
    logic                    accept;
    logic [16:0]             sext, mag;
    logic [33:0]             sq;
    logic [31:0]             acc_sum;
    logic [30:0]             acc_n;
    logic [evad_pkg::E_W-1:0] e_n;
    logic [evad_pkg::E_W-1:0] old;
    logic [SW-1:0]           sum_n;
    logic [SW:0]             nz;
    logic [XW-1:0]           keep;
    logic                    mul_start, mul_done;
    logic [TW-1:0]           mul_a;
    logic [BW-1:0]           mul_b;
    logic [PW-1:0]           mul_p;
    logic [XW-1:0]           rnd;
    logic [XW-1:0]           nshift, n5, noise_eff;
    logic                    dec_cond, speech;
    logic [XW-1:0]           noise_d;
    logic [LW-1:0]           hl, hs, lng, sht;
    logic [HOLD_DEPTH-1:0]   mask_l, mask_s;
    logic                    lo, so, out_free;
    evad_pkg::t_hist_ctl     hist_ctl;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;

    // Sample energy into the frame accumulator, saturating at 2^30
    always_comb begin
        sext    = {i_sample[15], i_sample};
        mag     = i_sample[15] ? (17'd0 - sext) : sext;
        sq      = 34'(mag) * 34'(mag);
        acc_sum = 32'(r_acc) + 32'((sq + 34'd2) >> 2);
        acc_n   = (acc_sum > 32'(1 << 30)) ? 31'(1 << 30) : acc_sum[30:0];
        e_n     = evad_pkg::E_W'((32'(acc_n) + 32'd4) >> 3);
    end

    // History running sum and noise estimate
    always_comb begin
        sum_n = r_sum - SW'(({1'b0, old} + 29'd2) >> 2) + SW'(({1'b0, r_e} + 29'd2) >> 2);
        nz    = {1'b0, sum_n} + (SW+1)'(8);
    end

    // Multiplier operand selection
    always_comb begin
        if (r_rise_sel) begin
            keep = (XW'(r_rise) < QONE) ? QONE - XW'(r_rise) : '0;
        end else begin
            keep = (XW'(r_fall) < Q_NINE) ? Q_NINE - XW'(r_fall) : '0;
        end
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            OP_ENV_KEEP: begin mul_a = TW'(r_env); mul_b = BW'(keep); end
            OP_ENV_RATE: begin
                mul_a = TW'(r_e);
                mul_b = BW'(r_rise_sel ? r_rise : r_fall);
            end
            OP_CT_TGT:   begin mul_a = TW'(r_env); mul_b = BW'(r_cratio); end
            OP_CT_OLD:   begin mul_a = r_cthr; mul_b = BW'(QONE - XW'(r_tau)); end
            OP_CT_NEW:   begin mul_a = r_tgt;  mul_b = r_tau; end
            OP_ST_TGT:   begin mul_a = TW'(r_env); mul_b = BW'(r_sratio); end
            OP_ST_OLD:   begin mul_a = r_sthr; mul_b = BW'(QONE - XW'(r_tau)); end
            OP_ST_NEW:   begin mul_a = r_tgt;  mul_b = r_tau; end
            default:     begin mul_a = '0; mul_b = '0; end
        endcase
        mul_start = (r_state == S_GO);
        rnd       = (XW'(mul_p) + HALF) >> F;
    end

    // Envelope clamp, noise substitution and speech decision terms
    always_comb begin
        nshift    = XW'(r_noise) << F;
        n5        = ((XW'(r_noise) << 2) + XW'(r_noise)) << F;
        noise_eff = (XW'(r_env) > n5) ? XW'(r_floor >> 3) : XW'(r_noise);
        dec_cond  = (XW'(r_e) > XW'(r_noise) + (XW'(r_cthr) >> F)) &&
                    (XW'(r_env) > (XW'(r_min_env) << F));
        noise_d   = r_in_speech ? XW'(r_noise) : '0;
        speech    = dec_cond && (XW'(r_e) > noise_d + (XW'(r_sthr) >> F));
    end

    // Hangover windows over the confirmed flags
    always_comb begin
        hl  = LW'(r_hold_long);
        hs  = LW'(r_hold_short);
        lng = (hl == '0) ? LW'(1) : ((hl > LW'(HOLD_DEPTH)) ? LW'(HOLD_DEPTH) : hl);
        sht = (hs == '0) ? LW'(1) : ((hs > LW'(HOLD_DEPTH)) ? LW'(HOLD_DEPTH) : hs);
        if (sht > lng) begin
            sht = lng;
        end
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            mask_l[i] = LW'(i) < lng;
            mask_s[i] = LW'(i) < sht;
        end
        lo = |(r_conf & mask_l);
        so = |(r_conf & mask_s);
    end

    assign hist_ctl.wr  = (r_state == S_RD);
    assign hist_ctl.clr = (r_state == S_DEC) && (dec_cond != r_in_speech);

    evad_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hist_ctl),
        .i_data  (r_e),
        .o_old   (old)
    );

    evad_mul #(
        .A_W (TW),
        .B_W (BW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise       <= evad_pkg::RISE_RST;
            r_fall       <= evad_pkg::FALL_RST;
            r_cratio     <= evad_pkg::RATIO_RST;
            r_sratio     <= evad_pkg::RATIO_RST;
            r_min_env    <= evad_pkg::MINENV_RST;
            r_hold_long  <= evad_pkg::LONG_RST;
            r_hold_short <= evad_pkg::SHORT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                evad_pkg::CFG_RISE:       r_rise       <= i_cfg_data[15:0];
                evad_pkg::CFG_FALL:       r_fall       <= i_cfg_data[15:0];
                evad_pkg::CFG_CHANGE:     r_cratio     <= i_cfg_data[19:0];
                evad_pkg::CFG_SPEECH:     r_sratio     <= i_cfg_data[19:0];
                evad_pkg::CFG_MIN_ENV:    r_min_env    <= i_cfg_data[27:0];
                evad_pkg::CFG_HOLD_LONG:  r_hold_long  <= i_cfg_data[6:0];
                evad_pkg::CFG_HOLD_SHORT: r_hold_short <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Frame sequencer and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_ENV_KEEP;
            r_acc       <= '0;
            r_sum       <= SUM_INIT;
            r_env       <= EW'(evad_pkg::INIT_ENERGY) << F;
            r_cthr      <= TW'(evad_pkg::INIT_THRESH) << F;
            r_sthr      <= TW'(evad_pkg::INIT_THRESH) << F;
            r_floor     <= evad_pkg::E_W'(evad_pkg::INIT_ENERGY);
            r_in_speech <= 1'b0;
            r_raw_prev  <= 1'b0;
            r_conf      <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            // Load a finished frame, or drop the beat once accepted
            if (r_state == S_HOLD && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_acc <= i_block_end ? '0 : acc_n;
                        if (i_block_end) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= sum_n;
                    r_op    <= OP_ENV_KEEP;
                    r_state <= S_GO;
                end
                S_GO: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mul_done) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    case (r_op)
                        OP_ENV_KEEP: begin
                            r_t1    <= TW'(rnd);
                            r_op    <= OP_ENV_RATE;
                            r_state <= S_GO;
                        end
                        OP_ENV_RATE: begin
                            r_env   <= EW'(f_min(XW'(mul_p) + XW'(r_t1), ENV_MAX));
                            r_state <= S_ENV;
                        end
                        OP_CT_TGT: begin
                            r_tgt   <= TW'(f_min(rnd, THR_MAX));
                            r_op    <= OP_CT_OLD;
                            r_state <= S_GO;
                        end
                        OP_CT_OLD: begin
                            r_t1    <= TW'(rnd);
                            r_op    <= OP_CT_NEW;
                            r_state <= S_GO;
                        end
                        OP_CT_NEW: begin
                            r_cthr  <= TW'(f_min(XW'(r_t1) + rnd, THR_MAX));
                            r_op    <= OP_ST_TGT;
                            r_state <= S_GO;
                        end
                        OP_ST_TGT: begin
                            r_tgt   <= TW'(f_min(rnd, THR_MAX));
                            r_op    <= OP_ST_OLD;
                            r_state <= S_GO;
                        end
                        OP_ST_OLD: begin
                            r_t1    <= TW'(rnd);
                            r_op    <= OP_ST_NEW;
                            r_state <= S_GO;
                        end
                        OP_ST_NEW: begin
                            r_sthr  <= TW'(f_min(XW'(r_t1) + rnd, THR_MAX));
                            r_state <= S_DEC;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_ENV: begin
                    if (XW'(r_env) < nshift) begin
                        r_env <= EW'(f_min(nshift, ENV_MAX));
                    end
                    r_state <= S_NOISE;
                end
                S_NOISE: begin
                    r_op    <= OP_CT_TGT;
                    r_state <= S_GO;
                end
                S_DEC: begin
                    if (dec_cond != r_in_speech) begin
                        r_sum <= '0;
                    end
                    r_in_speech <= dec_cond;
                    r_raw_prev  <= speech;
                    r_conf      <= {r_conf[HOLD_DEPTH-2:0], speech & r_raw_prev};
                    r_state     <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_free) begin
                        if (!r_in_speech && !lo && !so) begin
                            r_floor <= r_env[EW-1:F];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Frame payload registers
    always_ff @(posedge i_clk) begin
        if (accept && i_block_end) begin
            r_e <= e_n;
        end
        if (r_state == S_SUM) begin
            r_noise    <= NW'(nz >> 4);
            r_rise_sel <= (XW'(r_e) << F) > XW'(r_env);
        end
        if (r_state == S_NOISE) begin
            r_noise <= NW'(noise_eff);
            r_tau   <= BW'((XW'(r_e) > noise_eff + (XW'(r_cthr) >> F)) ? Q_SLOW : Q_FAST);
        end
        if (r_state == S_HOLD && out_free) begin
            r_now    <= r_raw_prev;
            r_long   <= lo;
            r_short  <= so;
            r_energy <= r_e;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_speech_now   = r_now;
    assign o_speech_long  = r_long;
    assign o_speech_short = r_short;
    assign o_frame_energy = r_energy;

endmodule

// ===== rtl/evad_chk.sv =====
`include "assert_macros.svh"

module evad_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     i_block_end,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_speech_long,
    input logic                     o_speech_short,
    input logic [evad_pkg::E_W-1:0] o_frame_energy
);

    // A stalled result beat stays offered
    `CHK_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped under stall")

    // A frame end starts multi-cycle work, so the input stalls next
    `CHK_NXT(a_end_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_block_end, o_in_stall, "no stall after frame end")

    // Short window lies inside the long one
    `CHK_IMP(a_short_long, i_clk, i_rst_n, o_out_valid && o_speech_short, o_speech_long, "short hangover without long")

    // Frame energy bounded by the saturated accumulator
    `CHK_IMP(a_energy_max, i_clk, i_rst_n, o_out_valid, o_frame_energy <= 28'd134217728, "frame energy out of range")

endmodule

bind energy_voice_activity_detector evad_chk u_evad_chk (.*);

// ===== tb/energy_voice_activity_detector_tb.sv =====
`timescale 1ns / 100ps

module energy_voice_activity_detector_tb;

    localparam logic [evad_pkg::IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int               TIMEOUT_CYCLES = 400000;
    localparam int               DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [15:0] sample;
        logic               block_end;
    } t_sample_beat;

    typedef struct {
        logic        speech_now;
        logic        speech_long;
        logic        speech_short;
        logic [27:0] frame_energy;
    } t_decision;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_sample = '0;
    logic               i_block_end = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_speech_now;
    logic               o_speech_long;
    logic               o_speech_short;
    logic [evad_pkg::E_W-1:0]   o_frame_energy;
    logic               i_cfg_we = 1'b0;
    logic [evad_pkg::IDX_W-1:0] i_cfg_idx = '0;
    logic [evad_pkg::CFG_W-1:0] i_cfg_data = '0;

    t_sample_beat sample_queue[$];
    t_decision    pending_decisions[$];
    t_sample_beat cur_beat;
    int           err_cnt = 0;
    int           frames_seen = 0;
    int           speech_frames = 0;
    int           long_frames = 0;
    int           cycle_cnt = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           hold_left = 0;
    bit           quiet = 1'b0;
    bit           hold_go = 1'b0;
    bit           hold_done = 1'b0;

    // detector copy: settings
    bit [63:0] rise_rate, fall_rate, change_ratio, speech_ratio;
    bit [63:0] min_envelope, hold_long, hold_short;
    // detector copy: state
    bit [63:0] energy_acc, history_sum, envelope;
    bit [63:0] change_thr, speech_thr, noise_floor;
    bit [63:0] energy_hist[64];
    bit        in_speech;
    bit [79:0] raw_flags, conf_flags;

    energy_voice_activity_detector u_top (.*);

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit [63:0] mulq(bit [63:0] a, bit [63:0] b);
        return (a >> 16) * b + (((a & 64'hFFFF) * b + 64'd32768) >> 16);
    endfunction

    function automatic bit [63:0] clip(bit [63:0] v, bit [63:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic bit [63:0] quarter(bit [63:0] h);
        return (h + 64'd2) >> 2;
    endfunction

    function automatic bit [63:0] hold_frames(bit [63:0] h);
        if (h == 0) return 1;
        if (h > 80) return 80;
        return h;
    endfunction

    function automatic bit [63:0] track_thr(bit [63:0] t, bit [63:0] ratio, bit [63:0] tau);
        bit [63:0] target;
        target = clip(mulq(envelope, ratio), (64'd1 << 46) - 1);
        return clip(mulq(t, 64'd65536 - tau) + mulq(target, tau), (64'd1 << 46) - 1);
    endfunction

    task automatic reset_detector();
        rise_rate = evad_pkg::RISE_RST; fall_rate = evad_pkg::FALL_RST;
        change_ratio = evad_pkg::RATIO_RST; speech_ratio = evad_pkg::RATIO_RST;
        min_envelope = evad_pkg::MINENV_RST;
        hold_long = evad_pkg::LONG_RST; hold_short = evad_pkg::SHORT_RST;
        energy_acc = 0;
        history_sum = 0;
        for (int i = 0; i < 64; i++) begin
            energy_hist[i] = evad_pkg::INIT_ENERGY;
            history_sum += quarter(evad_pkg::INIT_ENERGY);
        end
        envelope = 64'(evad_pkg::INIT_ENERGY) << 16;
        change_thr = 64'(evad_pkg::INIT_THRESH) << 16;
        speech_thr = 64'(evad_pkg::INIT_THRESH) << 16;
        noise_floor = evad_pkg::INIT_ENERGY;
        in_speech = 1'b0;
        raw_flags = '0;
        conf_flags = '0;
    endtask

    task automatic clear_hist();
        for (int i = 0; i < 64; i++) energy_hist[i] = 0;
        history_sum = 0;
    endtask

    // Advance the detector copy by one sample; queue a decision at frame end.
    task automatic advance_detector(t_sample_beat b);
        bit [63:0] s, mag, e, noise, tau, keep, lng, sht;
        bit        speech, lo, so;
        t_decision d;
        s = 64'(b.sample) & 64'hFFFF;
        mag = s[15] ? 64'h10000 - s : s;
        speech = 1'b0;
        energy_acc = clip(energy_acc + ((mag * mag + 2) >> 2), 64'd1 << 30);
        if (!b.block_end) return;
        e = (energy_acc + 4) >> 3;
        energy_acc = 0;
        // shift history
        history_sum -= quarter(energy_hist[63]);
        for (int i = 63; i > 0; i--) energy_hist[i] = energy_hist[i-1];
        energy_hist[0] = e;
        history_sum += quarter(e);
        noise = (history_sum + 8) >> 4;
        // envelope
        if ((e << 16) > envelope) begin
            keep = (rise_rate < 65536) ? 65536 - rise_rate : 0;
            envelope = e * rise_rate + mulq(envelope, keep);
        end else begin
            keep = (fall_rate < 58982) ? 58982 - fall_rate : 0;
            envelope = e * fall_rate + mulq(envelope, keep);
        end
        envelope = clip(envelope, (64'd1 << 44) - 1);
        if (envelope < (noise << 16)) envelope = clip(noise << 16, (64'd1 << 44) - 1);
        if (envelope > ((noise * 5) << 16)) noise = noise_floor >> 3;
        // thresholds
        tau = (e > noise + (change_thr >> 16)) ? 64'd66 : 64'd8192;
        change_thr = track_thr(change_thr, change_ratio, tau);
        speech_thr = track_thr(speech_thr, speech_ratio, tau);
        // speech/noise state
        if (e > noise + (change_thr >> 16) && envelope > (min_envelope << 16)) begin
            if (!in_speech) begin
                clear_hist();
                noise = 0;
            end
            in_speech = 1'b1;
            speech = e > noise + (speech_thr >> 16);
        end else begin
            if (in_speech) clear_hist();
            in_speech = 1'b0;
        end
        // hangover
        raw_flags = {raw_flags[78:0], speech};
        conf_flags = {conf_flags[78:0], raw_flags[0] & raw_flags[1]};
        lng = hold_frames(hold_long);
        sht = hold_frames(hold_short);
        if (sht > lng) sht = lng;
        lo = 1'b0;
        so = 1'b0;
        for (int i = 0; i < lng; i++) begin
            if (conf_flags[i]) begin
                lo = 1'b1;
                if (i < sht) so = 1'b1;
            end
        end
        if (!in_speech && !lo && !so) noise_floor = clip(envelope >> 16, 64'hFFFFFFF);
        d.speech_now = speech;
        d.speech_long = lo;
        d.speech_short = so;
        d.frame_energy = e[27:0];
        pending_decisions.push_back(d);
    endtask

    // Drive the sample channel from the queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_detector(cur_beat);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 4);
                        i_in_valid <= 1'b0;
                    end else begin
                        cur_beat = sample_queue.pop_front();
                        i_in_valid <= 1'b1;
                        i_sample <= cur_beat.sample;
                        i_block_end <= cur_beat.block_end;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Count down the long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 300;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Check each result beat and drive output stall
    always @(posedge i_clk) begin
        t_decision d;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_decisions.size() == 0) begin
                    $error("result with no frame pending");
                    err_cnt++;
                end else begin
                    d = pending_decisions.pop_front();
                    frames_seen++;
                    speech_frames += d.speech_now;
                    long_frames += d.speech_long;
                    if (o_speech_now !== d.speech_now) begin
                        $error("speech_now exp %0d got %0d", d.speech_now, o_speech_now);
                        err_cnt++;
                    end
                    if (o_speech_long !== d.speech_long) begin
                        $error("speech_long exp %0d got %0d", d.speech_long, o_speech_long);
                        err_cnt++;
                    end
                    if (o_speech_short !== d.speech_short) begin
                        $error("speech_short exp %0d got %0d", d.speech_short,
                               o_speech_short);
                        err_cnt++;
                    end
                    if (o_frame_energy !== d.frame_energy) begin
                        $error("frame_energy exp %0d got %0d", d.frame_energy,
                               o_frame_energy);
                        err_cnt++;
                    end
                end
            end
            // long hold-off, then random bursts
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 4);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [evad_pkg::IDX_W-1:0] idx, logic [evad_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            evad_pkg::CFG_RISE:       rise_rate = val[15:0];
            evad_pkg::CFG_FALL:       fall_rate = val[15:0];
            evad_pkg::CFG_CHANGE:     change_ratio = val[19:0];
            evad_pkg::CFG_SPEECH:     speech_ratio = val[19:0];
            evad_pkg::CFG_MIN_ENV:    min_envelope = val[27:0];
            evad_pkg::CFG_HOLD_LONG:  hold_long = val[6:0];
            evad_pkg::CFG_HOLD_SHORT: hold_short = val[6:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [evad_pkg::CFG_W-1:0] r, logic [evad_pkg::CFG_W-1:0] f,
                             logic [evad_pkg::CFG_W-1:0] c, logic [evad_pkg::CFG_W-1:0] s,
                             logic [evad_pkg::CFG_W-1:0] m,
                             logic [evad_pkg::CFG_W-1:0] hl,
                             logic [evad_pkg::CFG_W-1:0] hs);
        write_reg(evad_pkg::CFG_RISE, r);
        write_reg(evad_pkg::CFG_FALL, f);
        write_reg(evad_pkg::CFG_CHANGE, c);
        write_reg(evad_pkg::CFG_SPEECH, s);
        write_reg(evad_pkg::CFG_MIN_ENV, m);
        write_reg(evad_pkg::CFG_HOLD_LONG, hl);
        write_reg(evad_pkg::CFG_HOLD_SHORT, hs);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_beat(logic signed [15:0] s, logic be);
        t_sample_beat b;
        b.sample = s;
        b.block_end = be;
        sample_queue.push_back(b);
    endtask

    // kind: 0 quiet, 1 loud, 2 any value
    task automatic push_frame(int len, int kind);
        logic signed [15:0] s;
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: s = 16'($signed($urandom_range(0, 120)) - 60);
                1: s = $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 4000))
                                            : 16'sh8000 + 16'($urandom_range(0, 4000));
                default: s = 16'($urandom);
            endcase
            push_beat(s, i == len - 1);
        end
    endtask

    // Runs of quiet frames and loud bursts, with some noise frames
    task automatic push_talk(int n_beats);
        int left, len, kind, run;
        left = n_beats;
        while (left > 0) begin
            kind = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
            run = $urandom_range(1, 6);
            for (int r = 0; r < run && left > 0; r++) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 40)
                                                   : $urandom_range(1, 6);
                push_frame(len, kind);
                left -= len;
            end
        end
    endtask

    task automatic wait_idle();
        wait (sample_queue.size() == 0 && !i_in_valid && pending_decisions.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        reset_detector();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, saturating frame, lone samples
        push_beat(16'sh7FFF, 1'b1);
        push_beat(16'sh8000, 1'b1);
        push_beat(16'sh0000, 1'b1);
        push_beat(-16'sd1, 1'b0);
        push_beat(16'sd1, 1'b1);
        for (int i = 0; i < 6; i++) push_beat(16'sh8000, i == 5);
        for (int i = 0; i < 3; i++) push_frame(2, 1);
        for (int i = 0; i < 3; i++) push_frame(2, 0);
        push_frame(3, 2);
        wait_idle();

        // high rates and holds, zero ratios, unused index, long receiver hold-off with short frames
        write_reg(CFG_UNUSED, 28'hFFFFFFF);
        write_all(65535, 58982, 0, 0, 0, 80, 80);
        hold_go <= 1'b1;
        for (int i = 0; i < 40; i++) push_frame($urandom_range(1, 2), $urandom_range(0, 2));
        push_talk(100);
        wait_idle();

        // low rates and holds, high ratios and envelope minimum
        write_all(0, 0, 1048575, 1048575, 268435455, 1, 1);
        push_talk(100);
        wait_idle();

        // odd holds, short above long
        write_all(65535, 0, $urandom_range(0, 1048575), $urandom_range(0, 1048575),
                  0, 127, 0);
        push_talk(60);
        wait_idle();
        write_all($urandom_range(0, 4000), $urandom_range(0, 58982),
                  $urandom_range(30000, 200000), $urandom_range(30000, 200000),
                  $urandom_range(0, 5000), 3, 40);
        push_talk(100);
        wait_idle();

        // back near start-up values, no idling at the end
        write_all(evad_pkg::RISE_RST, evad_pkg::FALL_RST, evad_pkg::RATIO_RST,
                  evad_pkg::RATIO_RST, evad_pkg::MINENV_RST, evad_pkg::LONG_RST,
                  evad_pkg::SHORT_RST);
        push_talk(80);
        wait_idle();
        quiet = 1'b1;
        push_talk(80);
        wait_idle();

        $display("Checked %0d frames: %0d raw speech, %0d in long hangover.",
                 frames_seen, speech_frames, long_frames);
        $display("Covered six register settings and a 300-cycle output hold-off.");
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== energy_voice_activity_detector.f =====
+incdir+rtl
rtl/evad_pkg.sv
rtl/evad_mul.sv
rtl/evad_hist.sv
rtl/energy_voice_activity_detector.sv
rtl/evad_chk.sv
tb/energy_voice_activity_detector_tb.sv
